// ===== hw/rtl/bsd_pkg.sv =====
// Shared types and constants for the byte span to disk location translator.
// Holds the register index codes, reset values and the divider request and
// response structs. No dependencies.
package bsd_pkg;

  localparam int DIV_W       = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_PLATTERS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACKS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTORS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES    = 3'd4;

  localparam logic [4:0]  RST_PLATTERS = 5'd1;
  localparam logic [1:0]  RST_SURFACES = 2'd2;
  localparam logic [16:0] RST_TRACKS   = 17'd1024;
  localparam logic [10:0] RST_SECTORS  = 11'd64;
  localparam logic [12:0] RST_BYTES    = 13'd512;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hw/rtl/bsd_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bsd_pkg for the request and response structs.
module bsd_divider import bsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W:0]   rem;
  logic [DIV_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem[DIV_W-1:0], quo[DIV_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        count   <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem   <= fits ? (trial - {1'b0, divisor}) : trial;
        quo   <= {quo[DIV_W-2:0], fits};
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[DIV_W-1:0];

endmodule

// ===== hw/rtl/byte_span_to_disk_locations.sv =====
// Byte span to disk locations: turns a record's start byte and length into
// the platter, surface, track and sector of each sector it touches, up to
// MAX_LOCATIONS of them. Sequence: geometry products (S_PROD1 to S_PROD3), six
// passes through the shared bit-serial divider, then one location per transfer.
// A new span is taken only in idle, after the last location; empty spans give none.
// Reset: synchronous, active high; geometry registers return to defaults.
module byte_span_to_disk_locations import bsd_pkg::*; #(
  parameter int MAX_LOCATIONS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [30:0]            start_byte,
  input  logic [30:0]            span_length,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             platter,
  output logic                   surface,
  output logic [15:0]            track,
  output logic [9:0]             sector,
  output logic                   last,
  output logic                   truncated
);

  localparam int CNT_W = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PROD1   = 3'd1;
  localparam logic [2:0] S_PROD2   = 3'd2;
  localparam logic [2:0] S_PROD3   = 3'd3;
  localparam logic [2:0] S_DIVGO   = 3'd4;
  localparam logic [2:0] S_DIVWAIT = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_FINAL = 3'd1;
  localparam logic [2:0] STEP_ABS   = 3'd2;
  localparam logic [2:0] STEP_PLAT  = 3'd3;
  localparam logic [2:0] STEP_SURF  = 3'd4;
  localparam logic [2:0] STEP_TRACK = 3'd5;

  // Geometry registers as written.
  logic [4:0]  reg_platters;
  logic [1:0]  reg_surfaces;
  logic [16:0] reg_tracks;
  logic [10:0] reg_sectors;
  logic [12:0] reg_bytes;

  // Geometry after clamping to the legal range.
  logic [4:0]  np_c;
  logic        ns_two;
  logic [16:0] nt_c;
  logic [10:0] nc_c;
  logic [12:0] sb_c;

  logic [2:0]       state;
  logic [2:0]       step;
  logic [30:0]      start_r;
  logic [30:0]      len_r;
  logic [31:0]      last_byte;
  logic [26:0]      per_surface;
  logic [27:0]      per_platter;
  logic [31:0]      total;
  logic [30:0]      first_sec;
  logic             trunc;
  logic [CNT_W-1:0] left;
  logic [31:0]      residue;
  logic [3:0]       pos_platter;
  logic             pos_surface;
  logic [15:0]      pos_track;
  logic [9:0]       pos_sector;

  logic [31:0] span;
  logic        span_trunc;
  logic        sec_wrap;
  logic        trk_wrap;
  logic        srf_wrap;
  logic        plt_wrap;
  logic        emit_now;

  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_platters <= RST_PLATTERS;
      reg_surfaces <= RST_SURFACES;
      reg_tracks   <= RST_TRACKS;
      reg_sectors  <= RST_SECTORS;
      reg_bytes    <= RST_BYTES;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_PLATTERS: reg_platters <= cfg_data[4:0];
        REG_SURFACES: reg_surfaces <= cfg_data[1:0];
        REG_TRACKS:   reg_tracks   <= cfg_data[16:0];
        REG_SECTORS:  reg_sectors  <= cfg_data[10:0];
        REG_BYTES:    reg_bytes    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // A zero register acts as one and an oversized one as its upper bound.
  always_comb begin
    np_c   = (reg_platters == 5'd0) ? 5'd1 :
             (reg_platters > 5'd16) ? 5'd16 : reg_platters;
    ns_two = reg_surfaces[1];
    nt_c   = (reg_tracks == 17'd0) ? 17'd1 :
             (reg_tracks > 17'd65536) ? 17'd65536 : reg_tracks;
    nc_c   = (reg_sectors == 11'd0) ? 11'd1 :
             (reg_sectors > 11'd1024) ? 11'd1024 : reg_sectors;
    sb_c   = (reg_bytes == 13'd0) ? 13'd1 :
             (reg_bytes > 13'd4096) ? 13'd4096 : reg_bytes;
  end

  always_comb begin
    div_req.start = (state == S_DIVGO);
    case (step)
      STEP_FIRST: begin
        div_req.dividend = {1'b0, start_r};
        div_req.divisor  = {19'd0, sb_c};
      end
      STEP_FINAL: begin
        div_req.dividend = last_byte;
        div_req.divisor  = {19'd0, sb_c};
      end
      STEP_ABS: begin
        div_req.dividend = {1'b0, first_sec};
        div_req.divisor  = total;
      end
      STEP_PLAT: begin
        div_req.dividend = residue;
        div_req.divisor  = {4'd0, per_platter};
      end
      STEP_SURF: begin
        div_req.dividend = residue;
        div_req.divisor  = {5'd0, per_surface};
      end
      default: begin
        div_req.dividend = residue;
        div_req.divisor  = {21'd0, nc_c};
      end
    endcase
  end

  bsd_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sectors touched minus one, and whether the sectors touched exceed the location limit.
  always_comb begin
    span       = div_rsp.quotient - {1'b0, first_sec};
    span_trunc = (span >= 32'(MAX_LOCATIONS));
  end

  // The location steps like an odometer: sector, track, surface, platter.
  always_comb begin
    sec_wrap = ({1'b0, pos_sector} == (nc_c - 11'd1));
    trk_wrap = ({1'b0, pos_track} == (nt_c - 17'd1));
    srf_wrap = !ns_two || pos_surface;
    plt_wrap = ({1'b0, pos_platter} == (np_c - 5'd1));
    emit_now = (state == S_EMIT) && (!out_valid || !out_stall);
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_now) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            start_r <= start_byte;
            len_r   <= span_length;
            if (span_length != 31'd0) begin
              state <= S_PROD1;
            end
          end
        end
        S_PROD1: begin
          per_surface <= 27'(nc_c * nt_c);
          last_byte   <= {1'b0, start_r} + {1'b0, len_r} - 32'd1;
          step        <= STEP_FIRST;
          state       <= S_PROD2;
        end
        S_PROD2: begin
          per_platter <= ns_two ? {per_surface, 1'b0} : {1'b0, per_surface};
          state       <= S_PROD3;
        end
        S_PROD3: begin
          total <= 32'(per_platter * np_c);
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_rsp.done) begin
            case (step)
              STEP_FIRST: first_sec <= div_rsp.quotient[30:0];
              STEP_FINAL: begin
                trunc <= span_trunc;
                left  <= span_trunc ? CNT_W'(MAX_LOCATIONS - 1) : span[CNT_W-1:0];
              end
              STEP_ABS: residue <= div_rsp.remainder;
              STEP_PLAT: begin
                pos_platter <= div_rsp.quotient[3:0];
                residue     <= div_rsp.remainder;
              end
              STEP_SURF: begin
                pos_surface <= div_rsp.quotient[0];
                residue     <= div_rsp.remainder;
              end
              default: begin
                pos_track  <= div_rsp.quotient[15:0];
                pos_sector <= div_rsp.remainder[9:0];
              end
            endcase
            if (step == STEP_TRACK) begin
              state <= S_EMIT;
            end else begin
              step  <= step + 3'd1;
              state <= S_DIVGO;
            end
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            out_valid <= 1'b1;
            platter   <= pos_platter;
            surface   <= pos_surface;
            track     <= pos_track;
            sector    <= pos_sector;
            last      <= (left == '0);
            truncated <= (left == '0) && trunc;
            pos_sector <= sec_wrap ? 10'd0 : pos_sector + 10'd1;
            if (sec_wrap) begin
              pos_track <= trk_wrap ? 16'd0 : pos_track + 16'd1;
              if (trk_wrap) begin
                pos_surface <= srf_wrap ? 1'b0 : 1'b1;
                if (srf_wrap) begin
                  pos_platter <= plt_wrap ? 4'd0 : pos_platter + 4'd1;
                end
              end
            end
            if (left == '0) begin
              state <= S_IDLE;
            end else begin
              left <= left - CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider only answers a request that the sequencer is waiting on.
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVWAIT))
    else $error("divider finished outside of a wait state");

  // Leaving the emit state means the final location of the record was loaded.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) == S_EMIT && state == S_IDLE) |-> (out_valid && last))
    else $error("record ended without a final location");

  // The truncation flag only rides on the final location.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> last)
    else $error("truncation flagged on a location that is not the last");

endmodule

// ===== verif/tb_byte_span_to_disk_locations.sv =====
// Testbench for byte_span_to_disk_locations: random and directed byte spans
// under several disk geometries, checked location by location against a
// scoreboard that predicts them. Depends on bsd_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_byte_span_to_disk_locations;
  import bsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS   = 49;
  localparam int unsigned LOC_LIMIT     = 64;

  // Indexes that decode to no register; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [3:0]  platter;
    logic        surface;
    logic [15:0] track;
    logic [9:0]  sector;
    logic        last;
    logic        truncated;
  } disk_loc_t;

  class location_book;
    bit [4:0]  plat_reg;
    bit [1:0]  surf_reg;
    bit [16:0] trk_reg;
    bit [10:0] sec_reg;
    bit [12:0] byte_reg;
    disk_loc_t due[$];
    int unsigned fails;
    int unsigned spans;
    int unsigned cut_spans;
    int unsigned checked;

    function void reset_geometry();
      plat_reg = RST_PLATTERS;
      surf_reg = RST_SURFACES;
      trk_reg  = RST_TRACKS;
      sec_reg  = RST_SECTORS;
      byte_reg = RST_BYTES;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PLATTERS: plat_reg = val[4:0];
        REG_SURFACES: surf_reg = val[1:0];
        REG_TRACKS:   trk_reg  = val[16:0];
        REG_SECTORS:  sec_reg  = val[10:0];
        REG_BYTES:    byte_reg = val[12:0];
        default: ;
      endcase
    endfunction

    // A zero register behaves as one; anything past the top behaves as the top.
    function longint unsigned bounded(longint unsigned v, longint unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint unsigned sector_size();
      return bounded(byte_reg, 4096);
    endfunction

    function longint unsigned disk_sectors();
      return bounded(plat_reg, 16) * bounded(surf_reg, 2) *
             bounded(trk_reg, 65536) * bounded(sec_reg, 1024);
    endfunction

    function void add_span(bit [30:0] start, bit [30:0] len);
      longint unsigned nc, sb, per_surf, per_plat, total;
      longint unsigned lo_sec, hi_sec, count, emit, abs_sec, rem, rem2;
      disk_loc_t loc;
      spans++;
      if (len == 0) return;
      nc       = bounded(sec_reg, 1024);
      sb       = sector_size();
      per_surf = nc * bounded(trk_reg, 65536);
      per_plat = per_surf * bounded(surf_reg, 2);
      total    = disk_sectors();
      lo_sec   = start / sb;
      hi_sec   = (start + len - 1) / sb;
      count    = hi_sec - lo_sec + 1;
      emit     = (count > LOC_LIMIT) ? LOC_LIMIT : count;
      if (count > LOC_LIMIT) cut_spans++;
      for (longint unsigned k = 0; k < emit; k++) begin
        abs_sec       = (lo_sec + k) % total;
        rem           = abs_sec % per_plat;
        rem2          = rem % per_surf;
        loc.platter   = 4'(abs_sec / per_plat);
        loc.surface   = 1'(rem / per_surf);
        loc.track     = 16'(rem2 / nc);
        loc.sector    = 10'(rem2 % nc);
        loc.last      = (k + 1 == emit);
        loc.truncated = (k + 1 == emit) && (count > LOC_LIMIT);
        due.insert(due.size(), loc);
      end
    endfunction

    function void check_location(disk_loc_t got);
      disk_loc_t want;
      bit bad;
      checked++;
      if (due.size() == 0) begin
        $error("location transfer with nothing expected: platter %0d track %0d sector %0d",
               got.platter, got.track, got.sector);
        fails++;
        return;
      end
      want = due.pop_front();
      bad  = 0;
      if (got.platter !== want.platter) begin
        $error("platter: expected %0d, actual %0d", want.platter, got.platter);
        bad = 1;
      end
      if (got.surface !== want.surface) begin
        $error("surface: expected %0d, actual %0d", want.surface, got.surface);
        bad = 1;
      end
      if (got.track !== want.track) begin
        $error("track: expected %0d, actual %0d", want.track, got.track);
        bad = 1;
      end
      if (got.sector !== want.sector) begin
        $error("sector: expected %0d, actual %0d", want.sector, got.sector);
        bad = 1;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        bad = 1;
      end
      if (got.truncated !== want.truncated) begin
        $error("truncated: expected %0d, actual %0d", want.truncated, got.truncated);
        bad = 1;
      end
      if (bad) fails++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [30:0]            start_byte = '0;
  logic [30:0]            span_length = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [3:0]             platter;
  logic                   surface;
  logic [15:0]            track;
  logic [9:0]             sector;
  logic                   last;
  logic                   truncated;

  location_book book = new;
  bit           quiet = 1'b0;
  int unsigned  cycles = 0;
  int unsigned  geometries = 1;

  byte_span_to_disk_locations DUT (
    .clk, .rst, .cfg_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .start_byte, .span_length,
    .out_valid, .out_stall, .platter, .surface, .track, .sector, .last, .truncated
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Location side: a random stall before each transfer, none in quiet stretches.
  initial begin
    int unsigned hold;
    disk_loc_t got;
    wait (rst == 1'b0);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 14);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{platter, surface, track, sector, last, truncated};
      book.check_location(got);
    end
  end

  task automatic send_span(bit [30:0] start, bit [30:0] len);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    start_byte  <= start;
    span_length <= len;
    do @(posedge clk); while (in_stall);
    book.add_span(start, len);
  endtask

  // Holds off new spans until every predicted location has come back, then
  // leaves the block idle for a while before the geometry changes.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_en <= 1'b0;
    book.set_reg(idx, val);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] plats, logic [CFG_DATA_W-1:0] surfs,
                              logic [CFG_DATA_W-1:0] trks, logic [CFG_DATA_W-1:0] secs,
                              logic [CFG_DATA_W-1:0] bytes_per);
    write_reg(REG_PLATTERS, plats);
    write_reg(REG_SURFACES, surfs);
    write_reg(REG_TRACKS, trks);
    write_reg(REG_SECTORS, secs);
    write_reg(REG_BYTES, bytes_per);
    write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
              CFG_DATA_W'($urandom_range(0, 131071)));
    geometries++;
  endtask

  // Mostly spans of a few sectors, some empty, some huge enough to be cut short.
  function automatic bit [30:0] pick_length();
    int unsigned sel;
    longint unsigned reach;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel <= 2) return 31'($urandom());
    reach = book.sector_size() * $urandom_range(1, 6);
    return 31'($urandom_range(1, 32'(reach)));
  endfunction

  function automatic bit [30:0] pick_start();
    int unsigned sel;
    longint unsigned disk_end;
    sel = $urandom_range(0, 9);
    disk_end = book.disk_sectors() * book.sector_size();
    if (sel <= 2 && disk_end < 64'h8000_0000)
      return 31'(disk_end - $urandom_range(0, 32'(2 * book.sector_size())));
    if (sel == 3) return 31'($urandom_range(0, 32'(8 * book.sector_size())));
    return 31'($urandom());
  endfunction

  task automatic random_spans(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_span(pick_start(), pick_length());
    end
    quiet = 1'b0;
  endtask

  initial begin
    book.reset_geometry();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed spans on the reset geometry: 512-byte sectors, 131072 in all.
    send_span(31'd0, 31'd0);
    send_span(31'd0, 31'd1);
    send_span(31'd511, 31'd2);
    send_span(31'd0, 31'd32768);
    send_span(31'd0, 31'd32769);
    send_span(31'h7FFF_FFFF, 31'd1);
    send_span(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_span(31'd0, 31'h7FFF_FFFF);
    send_span(31'h7FFF_FFFF, 31'd0);
    send_span(31'd67108352, 31'd1024);
    send_span(31'd33553920, 31'd1024);
    send_span(31'd32256, 31'd2);
    send_span(31'd12345, 31'd511);
    send_span(31'h2AAA_AAAA, 31'd3000);
    send_span(31'h5555_5555, 31'h2AAA_AAAA);
    send_span(31'd1023, 31'd1);
    random_spans(PHASE_ITEMS);
    drain();

    // Every register zero behaves as a one-sector disk of one-byte sectors.
    set_geometry(17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
    random_spans(PHASE_ITEMS);
    drain();

    set_geometry(17'd16, 17'd2, 17'd65536, 17'd1024, 17'd4096);
    random_spans(PHASE_ITEMS);
    drain();

    // Values past the legal range behave as the top of the range.
    set_geometry(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    random_spans(PHASE_ITEMS);
    drain();

    set_geometry(17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
    random_spans(PHASE_ITEMS);
    drain();

    set_geometry(17'd3, 17'd1, 17'd5, 17'd7, 17'd9);
    random_spans(PHASE_ITEMS);
    drain();

    for (int unsigned p = 0; p < 2; p++) begin
      set_geometry(CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 3)),
                   CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 131071) :
                                                      $urandom_range(1, 20)),
                   CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 2047) :
                                                      $urandom_range(1, 12)),
                   CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 8191) :
                                                      $urandom_range(1, 16)));
      random_spans(PHASE_ITEMS);
      drain();
    end

    if (book.due.size() != 0) begin
      $error("%0d expected locations never arrived", book.due.size());
      book.fails++;
    end
    $display("Sent %0d spans over %0d disk geometries, %0d of them cut at %0d locations.",
             book.spans, geometries, book.cut_spans, LOC_LIMIT);
    $display("Checked %0d locations in %0d cycles.", book.checked, cycles);
    if (book.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
